FILE: src/mtg_pkg.sv
// shared constants, types and functions of the mersenne twister generator
package mtg_pkg;

	localparam int unsigned STATE_WORDS  = 624;
	localparam int unsigned SHIFT_OFFSET = 397;
	localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

	localparam logic [31:0] TWIST_MATRIX  = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_MASK_B = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_MASK_C = 32'hEFC6_0000;
	localparam logic [31:0] INIT_MULT     = 32'd1812433253;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

	localparam logic MODE_SEED    = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_UNSEEDED = 1'b1;

	// handshake between the seed sequencer and the chain
	typedef struct packed {
		logic busy;
		logic shift;
	} mtg_seed_ctl_t;

	// next word of the recurrence from the oldest, second oldest and middle taps
	function automatic logic [31:0] twist_word(input logic [31:0] x0, input logic [31:0] x1,
			input logic [31:0] xm);
		logic [31:0] x;
		logic [31:0] xa;
		x  = {x0[31], x1[30:0]};
		xa = {1'b0, x[31:1]};
		if (x[0]) begin
			xa = xa ^ TWIST_MATRIX;
		end
		return xm ^ xa;
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] y_in);
		logic [31:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_MASK_B);
		y = y ^ ((y << 15) & TEMPER_MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

FILE: src/mtg_if.sv
// request and response channel interfaces of the mersenne twister generator
interface mtg_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] seed_value;

	modport source (output valid, output mode, output seed_value, input ready);
	modport sink (input valid, input mode, input seed_value, output ready);
endinterface

interface mtg_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;
	logic        status;

	modport source (output valid, output random_word, output status, input ready);
	modport sink (input valid, input random_word, input status, output ready);
endinterface

FILE: src/mtg_cell.sv
// one state word of the shift chain, loads its neighbor's word on shift
module mtg_cell (
	input  logic        clk,
	input  logic        shift,
	input  logic [31:0] d,
	output logic [31:0] q
);

	logic [31:0] word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

FILE: src/mtg_seeder.sv
// seed sequencer: produces the 624 initialization words through alternating multiply and add phases
module mtg_seeder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [31:0]                    seed_value,
	output mtg_pkg::mtg_seed_ctl_t         ctl,
	output logic [31:0]                    word
);

	logic                      busy_q;
	logic                      phase_q;
	logic [mtg_pkg::IDX_W-1:0] idx_q;
	logic [31:0]               prev_q;
	logic [31:0]               prod_q;
	logic [31:0]               sum;

	// multiply phase then add-and-emit phase
	assign sum = prod_q + 32'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			idx_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			idx_q   <= mtg_pkg::IDX_W'(1);
		end else if (busy_q) begin
			phase_q <= ~phase_q;
			if (phase_q) begin
				idx_q <= idx_q + mtg_pkg::IDX_W'(1);
				if (idx_q == mtg_pkg::LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prev_q <= seed_value;
		end else if (busy_q) begin
			if (!phase_q) begin
				prod_q <= mtg_pkg::INIT_MULT * (prev_q ^ (prev_q >> 30));
			end else begin
				prev_q <= sum;
			end
		end
	end

	assign ctl.busy  = busy_q;
	assign ctl.shift = start | (busy_q & phase_q);
	assign word      = start ? seed_value : sum;

endmodule

FILE: src/mersenne_twister_generator.sv
// top level of the mt19937 generator: 624-cell shift chain, seed sequencer, output register
//
//  channel | dir | beat fields              | meaning
//  --------+-----+--------------------------+------------------------------------------
//  req     | in  | mode, seed_value         | mode 0 reseeds, mode 1 asks for a word
//  rsp     | out | random_word, status      | one beat per extract, none per seed
//
// a seeded extract shifts the chain once, the new word comes from taps 0, 1 and 397
// a seed keeps the block busy while the sequencer's multiply/add loop emits its words,
// and req.ready stays low until the chain holds all 624 words
// after reset the block is unseeded and extracts answer status 1 with a zero word
// the output register lets a new beat in while the held one is taken in the same cycle
module mersenne_twister_generator (
	input logic     clk,
	input logic     arst_n,
	mtg_req_if.sink   req,
	mtg_rsp_if.source rsp
);

	localparam int unsigned N = mtg_pkg::STATE_WORDS;

	mtg_pkg::mtg_seed_ctl_t seed_ctl;
	logic [31:0]            seed_word;
	logic [31:0]            cell_q [N];
	logic [31:0]            chain_in;
	logic [31:0]            new_word;
	logic                   chain_shift;
	logic                   accept;
	logic                   seed_start;
	logic                   extract;
	logic                   seeded_q;
	logic                   rsp_valid_q;
	logic [31:0]            rsp_word_q;
	logic                   rsp_status_q;

	// take a request only when idle and the response slot is free or emptying
	assign req.ready  = ~seed_ctl.busy & (~rsp_valid_q | rsp.ready);
	assign accept     = req.valid & req.ready;
	assign seed_start = accept & (req.mode == mtg_pkg::MODE_SEED);
	assign extract    = accept & (req.mode == mtg_pkg::MODE_EXTRACT);

	mtg_seeder u_seeder (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (seed_start),
		.seed_value (req.seed_value),
		.ctl        (seed_ctl),
		.word       (seed_word)
	);

	// streaming form of the twist: the newest word enters at the tail
	assign new_word    = mtg_pkg::twist_word(cell_q[0], cell_q[1], cell_q[mtg_pkg::SHIFT_OFFSET]);
	assign chain_shift = seed_ctl.shift | (extract & seeded_q);
	assign chain_in    = seed_ctl.shift ? seed_word : new_word;

	// cell 0 holds the oldest word, words move one cell toward the head per shift
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == N - 1) begin : g_tail
			mtg_cell u_cell (
				.clk   (clk),
				.shift (chain_shift),
				.d     (chain_in),
				.q     (cell_q[i])
			);
		end else begin : g_body
			mtg_cell u_cell (
				.clk   (clk),
				.shift (chain_shift),
				.d     (cell_q[i+1]),
				.q     (cell_q[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
		end else if (seed_start) begin
			seeded_q <= 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (extract) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (extract) begin
			if (seeded_q) begin
				rsp_word_q   <= mtg_pkg::temper(new_word);
				rsp_status_q <= mtg_pkg::STATUS_OK;
			end else begin
				rsp_word_q   <= '0;
				rsp_status_q <= mtg_pkg::STATUS_UNSEEDED;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.random_word = rsp_word_q;
	assign rsp.status      = rsp_status_q;

endmodule
